>>> rtl/jsu_pkg.sv
// Shared types, codes and UTF-8 helpers for the JSON string unescape block.
package jsu_pkg;

  // Default depth of the job queue between the front and back parts.
  localparam int JSU_QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_CONTROL   = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;

  // Characters and code points that the decoder tests for.
  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_U         = 8'h75;
  localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR_LO   = 16'hD800;
  localparam logic [15:0] HI_SURR_HI   = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO   = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI   = 16'hDFFF;

  // Input beat: one raw byte of JSON text or the end-of-text mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } text_beat_t;

  // Output beat: one result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       last;
  } result_beat_t;

  // What follows the optional replacement character in a job.
  typedef enum logic [1:0] {
    MAIN_NONE  = 2'd0,
    MAIN_CP    = 2'd1,
    MAIN_CLOSE = 2'd2,
    MAIN_ERROR = 2'd3
  } main_kind_t;

  // One classified input byte: the results it causes, in compact form.
  // A raw job carries a string byte that passes through as it is, not UTF-8 encoded.
  typedef struct packed {
    logic       fffd;
    main_kind_t main;
    logic       raw;
    logic [20:0] cp;
    logic [2:0] err;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < 21'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte j (from 0) of the UTF-8 encoding of cp.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] j);
    logic [2:0] len;
    logic [7:0] b;
    len = utf8_len(cp);
    b = 8'h00;
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (j)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (j)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> rtl/jsu_front.sv
// Front part: accepts text bytes, tracks the string and escape state, emits jobs.
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_ready,
  input  jsu_pkg::text_beat_t text,
  input  logic               queue_full,
  output logic               push,
  output jsu_pkg::job_t      push_job
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_STR    = 7'b0000010,
    M_ESC    = 7'b0000100,
    M_HEX    = 7'b0001000,
    M_HIWAIT = 7'b0010000,
    M_HIBS   = 7'b0100000,
    M_LOHEX  = 7'b1000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic [9:0]  hi, hi_next;
  job_t        job;
  logic        accept;

  // Outcome of a byte taken as an ordinary string byte.
  main_kind_t  str_main;
  logic [2:0]  str_err;
  mode_t       str_mode;
  // Outcome of a byte taken as the character after a backslash.
  main_kind_t  esc_main;
  logic [7:0]  esc_val;
  mode_t       esc_mode;
  // Hex digit decode and the completed four-digit value.
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_new;
  logic        is_high, is_low;

  logic [7:0]  b;

  assign b          = text.in_byte;
  assign text_ready = !queue_full;
  assign accept     = text_valid && text_ready;

  always_comb begin
    str_err = ERR_CONTROL;
    if (b == CH_QUOTE) begin
      str_main = MAIN_CLOSE;
      str_mode = M_IDLE;
    end else if (b < CH_SPACE) begin
      str_main = MAIN_ERROR;
      str_mode = M_IDLE;
    end else if (b == CH_BACKSLASH) begin
      str_main = MAIN_NONE;
      str_mode = M_ESC;
    end else begin
      str_main = MAIN_CP;
      str_mode = M_STR;
    end
  end

  always_comb begin
    esc_main = MAIN_CP;
    esc_mode = M_STR;
    esc_val  = 8'h00;
    case (b)
      8'h22: esc_val = 8'h22;
      8'h5C: esc_val = 8'h5C;
      8'h2F: esc_val = 8'h2F;
      8'h62: esc_val = 8'h08;
      8'h66: esc_val = 8'h0C;
      8'h6E: esc_val = 8'h0A;
      8'h72: esc_val = 8'h0D;
      8'h74: esc_val = 8'h09;
      8'h75: begin
        esc_main = MAIN_NONE;
        esc_mode = M_HEX;
      end
      default: begin
        esc_main = MAIN_ERROR;
        esc_mode = M_IDLE;
      end
    endcase
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (b inside {[8'h30:8'h39]}) begin
      hex_val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    acc_new = {acc[11:0], hex_val};
    is_high = (acc_new >= HI_SURR_LO) && (acc_new <= HI_SURR_HI);
    is_low  = (acc_new >= LO_SURR_LO) && (acc_new <= LO_SURR_HI);
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    hi_next   = hi;
    job.fffd  = 1'b0;
    job.main  = MAIN_NONE;
    job.raw   = 1'b0;
    job.cp    = '0;
    job.err   = ERR_CONTROL;

    if (text.end_of_text) begin
      mode_next = M_IDLE;
      job.main  = MAIN_ERROR;
      case (mode)
        M_STR:    job.err = ERR_UNTERM;
        M_ESC:    job.err = ERR_TRUNCATED;
        M_HEX:    job.err = ERR_BAD_HEX;
        M_HIWAIT: begin
          job.fffd = 1'b1;
          job.err  = ERR_UNTERM;
        end
        M_HIBS: begin
          job.fffd = 1'b1;
          job.err  = ERR_TRUNCATED;
        end
        M_LOHEX: begin
          job.fffd = 1'b1;
          job.err  = ERR_BAD_HEX;
        end
        default: job.main = MAIN_NONE;
      endcase
    end else begin
      case (mode)
        M_STR, M_HIWAIT: begin
          if (mode == M_HIWAIT && b == CH_BACKSLASH) begin
            mode_next = M_HIBS;
          end else begin
            // A plain string byte is copied out unchanged, whatever its value.
            job.fffd  = (mode == M_HIWAIT);
            job.main  = str_main;
            job.raw   = 1'b1;
            job.err   = str_err;
            job.cp    = {13'd0, b};
            mode_next = str_mode;
          end
        end
        M_ESC, M_HIBS: begin
          if (mode == M_HIBS && b == CH_U) begin
            mode_next = M_LOHEX;
          end else begin
            job.fffd  = (mode == M_HIBS);
            job.main  = esc_main;
            job.err   = ERR_UNKNOWN;
            job.cp    = {13'd0, esc_val};
            mode_next = esc_mode;
          end
        end
        M_HEX, M_LOHEX: begin
          if (!hex_ok) begin
            job.fffd  = (mode == M_LOHEX);
            job.main  = MAIN_ERROR;
            job.err   = ERR_BAD_HEX;
            mode_next = M_IDLE;
          end else if (cnt != 2'd3) begin
            acc_next = acc_new;
            cnt_next = cnt + 2'd1;
          end else if (mode == M_LOHEX && is_low) begin
            // Surrogate pair: join into one supplementary code point.
            job.main  = MAIN_CP;
            job.cp    = CP_SUPP_BASE + {1'b0, hi, acc_new[9:0]};
            mode_next = M_STR;
          end else begin
            job.fffd = (mode == M_LOHEX);
            if (is_high) begin
              hi_next   = acc_new[9:0];
              mode_next = M_HIWAIT;
            end else begin
              job.main  = MAIN_CP;
              job.cp    = is_low ? CP_REPLACE : {5'd0, acc_new};
              mode_next = M_STR;
            end
          end
        end
        default: begin
          mode_next = (b == CH_QUOTE) ? M_STR : M_IDLE;
        end
      endcase
    end

    // Hex digits only live inside an escape; a finished or abandoned one starts afresh.
    if (!((mode_next == M_HEX || mode_next == M_LOHEX) &&
          (mode == M_HEX || mode == M_LOHEX))) begin
      acc_next = '0;
      cnt_next = '0;
    end
    if (!(mode_next == M_HIWAIT || mode_next == M_HIBS || mode_next == M_LOHEX)) begin
      hi_next = '0;
    end
  end

  assign push     = accept && (job.fffd || job.main != MAIN_NONE);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc  <= '0;
      cnt  <= '0;
      hi   <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      hi   <= hi_next;
    end
  end

endmodule

>>> rtl/jsu_queue.sv
// Job queue between the front and back parts.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::job_t head
);
  import jsu_pkg::*;

  // DEPTH must be a power of two, at least two, so that the pointers wrap by themselves; nothing checks it.
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [IW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + IW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/jsu_back.sv
// Back part: expands each job into result beats through an output register.
module jsu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  jsu_pkg::job_t         head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_ready,
  output jsu_pkg::result_beat_t result
);
  import jsu_pkg::*;

  logic [2:0]   idx;
  logic [2:0]   main_count;
  logic [2:0]   total;
  logic [2:0]   main_idx;
  logic         in_fffd;
  logic         is_last;
  logic         load;
  result_beat_t beat;

  always_comb begin
    case (head.main)
      MAIN_CP:    main_count = head.raw ? 3'd1 : utf8_len(head.cp);
      MAIN_CLOSE: main_count = 3'd1;
      MAIN_ERROR: main_count = 3'd1;
      default:    main_count = 3'd0;
    endcase
    total    = main_count + (head.fffd ? 3'd3 : 3'd0);
    in_fffd  = head.fffd && (idx < 3'd3);
    main_idx = idx - (head.fffd ? 3'd3 : 3'd0);
    is_last  = (idx == total - 3'd1);

    beat.kind       = KIND_DATA;
    beat.data_byte  = 8'h00;
    beat.error_code = ERR_CONTROL;
    beat.last       = is_last;
    if (in_fffd) begin
      beat.data_byte = utf8_byte(CP_REPLACE, idx[1:0]);
    end else begin
      case (head.main)
        MAIN_CLOSE: beat.kind = KIND_CLOSE;
        MAIN_ERROR: begin
          beat.kind       = KIND_ERROR;
          beat.error_code = head.err;
        end
        default: begin
          beat.data_byte = head.raw ? head.cp[7:0] : utf8_byte(head.cp, main_idx[1:0]);
        end
      endcase
    end
  end

  assign load = head_valid && (!result_valid || result_ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        idx          <= is_last ? 3'd0 : idx + 3'd1;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescape and UTF-8 encode block.
//
//   Channel  Direction  Handshake                    Beat contents
//   text     in         text_valid / text_ready      in_byte, end_of_text
//   result   out        result_valid / result_ready  kind, data_byte, error_code, last
//
// The front part takes one text beat in every cycle in which the job queue has room and
// leaves one job in the queue for each byte that causes results. The back part turns a
// job into one to six result beats, one a cycle while the receiver is ready: a plain
// character gives one beat; a replacement character followed by a three-byte sequence, six.
// Reset clears the decoder to idle, empties the queue and drops any held result beat.
// A result stall fills the queue and then holds text_ready low; a text gap lets it drain.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  jsu_pkg::text_beat_t   text,
  output logic                  result_valid,
  input  logic                  result_ready,
  output jsu_pkg::result_beat_t result
);
  import jsu_pkg::*;

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head;

  // Classification of every text byte against the decoder state.
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Short queue so that either side can stall without stopping the other at once.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Expansion of jobs into UTF-8 bytes, close marks and error reports.
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the JSON string unescape and UTF-8 encode block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // The run is cut short here if the results stop arriving.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last expected beat for any stray beat to show up.
  localparam int SETTLE_CYCLES = 50;
  // The error field carries zero on every beat that is not an error.
  localparam logic [2:0] NO_ERROR = 3'd0;

  // States of the decoder as the predictor tracks them.
  typedef enum logic [2:0] {
    DM_IDLE,
    DM_STRING,
    DM_ESCAPE,
    DM_HEX,
    DM_HIGH_WAIT,
    DM_HIGH_BSLASH,
    DM_LOW_HEX
  } decoder_mode_t;

  logic         clk;
  logic         rst;
  logic         text_valid;
  logic         text_ready;
  text_beat_t   text;
  logic         result_valid;
  logic         result_ready;
  result_beat_t result;

  // Predictor state: a private copy of what the decoder holds.
  decoder_mode_t dec_mode = DM_IDLE;
  logic [15:0]   hex_acc = '0;
  logic [1:0]    hex_cnt = '0;
  logic [9:0]    hi_surr = '0;
  logic          hi_pend = 1'b0;

  result_beat_t  step_beats[$];        // beats caused by the byte being predicted
  result_beat_t  expected_results[$];  // decoded beats still owed by the block
  text_beat_t    text_backlog[$];      // text beats queued up for the sender

  int fail_count = 0;
  int string_beats_sent = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;     // chance per cycle that the sender holds back
  int ready_stall_pct = 0;  // chance per cycle that the receiver holds back
  int hold_request = 0;     // asks the receiver for a long hold-off
  int hold_left = 0;

  json_string_unescape_utf8 dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Each accepted text beat is run through these functions, which
  // leave the resulting beats in step_beats and then on the expected queue.
  // ---------------------------------------------------------------------------

  function automatic void add_beat(input logic [1:0] k, input logic [7:0] d,
                                   input logic [2:0] e);
    result_beat_t r;
    // The block never produces more than six beats for one byte.
    if (step_beats.size() >= 6) return;
    r.kind       = k;
    r.data_byte  = d;
    r.error_code = e;
    r.last       = 1'b0;
    step_beats.insert(step_beats.size(), r);
  endfunction

  function automatic void clear_decoder();
    dec_mode = DM_IDLE;
    hex_acc  = '0;
    hex_cnt  = '0;
    hi_surr  = '0;
    hi_pend  = 1'b0;
  endfunction

  // An error beat always ends the string and sends the decoder back to idle.
  function automatic void report_error(input logic [2:0] code);
    add_beat(KIND_ERROR, 8'h00, code);
    clear_decoder();
  endfunction

  // UTF-8 encoding of one code point, one to four data beats.
  function automatic void add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_beat(KIND_DATA, cp[7:0], NO_ERROR);
    end else if (cp < 21'h800) begin
      add_beat(KIND_DATA, 8'hC0 | cp[10:6], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[5:0], NO_ERROR);
    end else if (cp < 21'h10000) begin
      add_beat(KIND_DATA, 8'hE0 | cp[15:12], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[11:6], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[5:0], NO_ERROR);
    end else begin
      add_beat(KIND_DATA, 8'hF0 | cp[20:18], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[17:12], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[11:6], NO_ERROR);
      add_beat(KIND_DATA, 8'h80 | cp[5:0], NO_ERROR);
    end
  endfunction

  function automatic int hex_val(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // A pending high surrogate that finds no partner turns into U+FFFD.
  function automatic void drop_high_surrogate();
    hi_pend = 1'b0;
    hi_surr = '0;
    add_code_point(CP_REPLACE);
  endfunction

  // A complete \u value that is not the low half of a pair.
  function automatic void finish_escape_value(input logic [15:0] v);
    hex_acc = '0;
    hex_cnt = '0;
    if (v >= HI_SURR_LO && v <= HI_SURR_HI) begin
      hi_surr  = v[9:0];
      hi_pend  = 1'b1;
      dec_mode = DM_HIGH_WAIT;
    end else begin
      if (v >= LO_SURR_LO && v <= LO_SURR_HI) begin
        add_code_point(CP_REPLACE);
      end else begin
        add_code_point({5'd0, v});
      end
      dec_mode = DM_STRING;
    end
  endfunction

  function automatic void string_char(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      add_beat(KIND_CLOSE, 8'h00, NO_ERROR);
      clear_decoder();
    end else if (b < CH_SPACE) begin
      report_error(ERR_CONTROL);
    end else if (b == CH_BACKSLASH) begin
      dec_mode = DM_ESCAPE;
    end else begin
      add_beat(KIND_DATA, b, NO_ERROR);
      dec_mode = DM_STRING;
    end
  endfunction

  function automatic void escape_char(input logic [7:0] e);
    logic [7:0] o;
    o = 8'h00;
    case (e)
      CH_QUOTE:     o = CH_QUOTE;
      CH_BACKSLASH: o = CH_BACKSLASH;
      "/":          o = 8'h2F;
      "b":          o = 8'h08;
      "f":          o = 8'h0C;
      "n":          o = 8'h0A;
      "r":          o = 8'h0D;
      "t":          o = 8'h09;
      CH_U: begin
        hex_acc  = '0;
        hex_cnt  = '0;
        dec_mode = DM_HEX;
        return;
      end
      default: begin
        report_error(ERR_UNKNOWN);
        return;
      end
    endcase
    add_beat(KIND_DATA, o, NO_ERROR);
    dec_mode = DM_STRING;
  endfunction

  function automatic void predict_text_beat(input text_beat_t t);
    decoder_mode_t m;
    logic [7:0]    b;
    logic [20:0]   cp;
    result_beat_t  r;
    int            h;
    m = dec_mode;
    b = t.in_byte;
    step_beats.delete();
    if (t.end_of_text) begin
      // Where the text stops decides the error; a waiting high surrogate
      // is flushed as U+FFFD first.
      case (m)
        DM_STRING:  report_error(ERR_UNTERM);
        DM_ESCAPE:  report_error(ERR_TRUNCATED);
        DM_HEX:     report_error(ERR_BAD_HEX);
        DM_HIGH_WAIT: begin
          drop_high_surrogate();
          report_error(ERR_UNTERM);
        end
        DM_HIGH_BSLASH: begin
          drop_high_surrogate();
          report_error(ERR_TRUNCATED);
        end
        DM_LOW_HEX: begin
          drop_high_surrogate();
          report_error(ERR_BAD_HEX);
        end
        default: clear_decoder();
      endcase
    end else begin
      case (m)
        DM_STRING: string_char(b);
        DM_ESCAPE: escape_char(b);
        DM_HEX, DM_LOW_HEX: begin
          h = hex_val(b);
          if (h < 0) begin
            if (m == DM_LOW_HEX) drop_high_surrogate();
            report_error(ERR_BAD_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], h[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else if (m == DM_LOW_HEX && hex_acc >= LO_SURR_LO &&
                         hex_acc <= LO_SURR_HI) begin
              // High and low halves join into one supplementary code point.
              cp = CP_SUPP_BASE + {1'b0, hi_surr, 10'd0} + {5'd0, hex_acc - LO_SURR_LO};
              hi_pend  = 1'b0;
              hi_surr  = '0;
              hex_acc  = '0;
              hex_cnt  = '0;
              add_code_point(cp);
              dec_mode = DM_STRING;
            end else begin
              if (m == DM_LOW_HEX) drop_high_surrogate();
              finish_escape_value(hex_acc);
            end
          end
        end
        DM_HIGH_WAIT: begin
          if (b == CH_BACKSLASH) begin
            dec_mode = DM_HIGH_BSLASH;
          end else begin
            drop_high_surrogate();
            string_char(b);
          end
        end
        DM_HIGH_BSLASH: begin
          if (b == CH_U) begin
            hex_acc  = '0;
            hex_cnt  = '0;
            dec_mode = DM_LOW_HEX;
          end else begin
            drop_high_surrogate();
            escape_char(b);
          end
        end
        default: begin
          clear_decoder();
          if (b == CH_QUOTE) dec_mode = DM_STRING;
        end
      endcase
    end
    if (step_beats.size() > 0) begin
      r = step_beats[$];
      r.last = 1'b1;
      step_beats[$] = r;
    end
    foreach (step_beats[i]) expected_results.insert(expected_results.size(), step_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge in one process, so a
  // text beat is predicted before any result beat of the same edge is checked.
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_result_beat(input result_beat_t got);
    result_beat_t want;
    string        msg;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("unexpected result beat: kind %0d data %02h err %0d last %0b",
                             got.kind, got.data_byte, got.error_code, got.last));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
        got.error_code !== want.error_code || got.last !== want.last) begin
      msg = $sformatf("result mismatch: expected kind %0d data %02h err %0d last %0b,",
                      want.kind, want.data_byte, want.error_code, want.last);
      msg = {msg, $sformatf(" got kind %0d data %02h err %0d last %0b",
                            got.kind, got.data_byte, got.error_code, got.last)};
      note_failure(msg);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && text_ready) predict_text_beat(text);
      if (result_valid && result_ready) check_result_beat(result);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Ready changes at the falling edge: either it sits out a long
  // hold-off that a test has asked for, or it stalls at random.
  // ---------------------------------------------------------------------------

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  // Watchdog: the run is declared failed if it is still going at the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender. A beat is offered at a falling edge, possibly after some idle
  // cycles, and held until the rising edge at which ready is seen high. Each
  // falling edge gives valid at most one new value.
  // ---------------------------------------------------------------------------

  task automatic send_beat(input text_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text       <= b;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  task automatic send_queued();
    foreach (text_backlog[i]) send_beat(text_backlog[i]);
    string_beats_sent += text_backlog.size();
    text_backlog.delete();
  endtask

  // Drop valid and wait until every beat owed so far has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    text_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic void push_byte(input logic [7:0] b);
    text_beat_t t;
    t.in_byte     = b;
    t.end_of_text = 1'b0;
    text_backlog.insert(text_backlog.size(), t);
  endfunction

  // End of text; the byte that travels with it is noise and must be ignored.
  function automatic void push_end();
    text_beat_t t;
    t.in_byte     = 8'($urandom_range(255));
    t.end_of_text = 1'b1;
    text_backlog.insert(text_backlog.size(), t);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic void push_hex_digits(input logic [15:0] v, input int count);
    for (int i = 0; i < count; i++) push_byte(hex_char(v[15 - 4*i -: 4]));
  endfunction

  function automatic void push_u(input logic [15:0] v);
    push_byte(CH_BACKSLASH);
    push_byte(CH_U);
    push_hex_digits(v, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Random content.
  // ---------------------------------------------------------------------------

  // Any byte that passes through a string unchanged.
  function automatic logic [7:0] random_plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'hFF));
    if (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'h61;
    return b;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (hex_val(b) >= 0) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] random_unknown_escape();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_QUOTE || b == CH_BACKSLASH || b == CH_U || b == "/" || b == "b" ||
           b == "f" || b == "n" || b == "r" || b == "t") begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  function automatic void push_simple_escape();
    logic [7:0] codes[8];
    codes = '{CH_QUOTE, CH_BACKSLASH, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
    push_byte(CH_BACKSLASH);
    push_byte(codes[$urandom_range(7)]);
  endfunction

  // A \u value spread over the UTF-8 lengths; the last class may be anything.
  function automatic logic [15:0] random_bmp_value();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] random_high();
    return HI_SURR_LO + 16'($urandom_range(10'h3FF));
  endfunction

  function automatic logic [15:0] random_low();
    return LO_SURR_LO + 16'($urandom_range(10'h3FF));
  endfunction

  // A \u escape broken by a non-hex byte after zero to three good digits.
  function automatic void push_bad_hex();
    push_byte(CH_BACKSLASH);
    push_byte(CH_U);
    push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
    push_byte(random_non_hex());
  endfunction

  // One piece of string body. Pieces that end in an error set aborted, since
  // the decoder is idle again after them.
  function automatic void queue_segment(output bit aborted);
    int sel;
    aborted = 1'b0;
    sel = $urandom_range(99);
    if (sel < 40) begin
      push_byte(random_plain_byte());
    end else if (sel < 52) begin
      push_simple_escape();
    end else if (sel < 63) begin
      push_u(random_bmp_value());
    end else if (sel < 72) begin
      push_u(random_high());
      push_u(random_low());
    end else if (sel < 77) begin
      push_u(random_low());
    end else if (sel < 88) begin
      // A high surrogate followed by everything that can break the pair.
      push_u(random_high());
      case ($urandom_range(6))
        0: push_byte(random_plain_byte());
        1: push_simple_escape();
        2: push_u(random_bmp_value());
        3: push_u(random_high());
        4: begin
          push_byte(CH_BACKSLASH);
          push_byte(random_unknown_escape());
          aborted = 1'b1;
        end
        5: begin
          push_bad_hex();
          aborted = 1'b1;
        end
        default: ;
      endcase
    end else if (sel < 92) begin
      push_bad_hex();
      aborted = 1'b1;
    end else if (sel < 96) begin
      push_byte(CH_BACKSLASH);
      push_byte(random_unknown_escape());
      aborted = 1'b1;
    end else begin
      push_byte(8'($urandom_range(8'h1F)));
      aborted = 1'b1;
    end
  endfunction

  // Most strings close normally; the rest stop short at every kind of position.
  function automatic void queue_string_end();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) begin
      push_byte(CH_QUOTE);
      return;
    end
    if (sel >= 89) push_u(random_high());
    if (sel >= 85 && sel < 89 || sel >= 96 && sel < 98) begin
      push_byte(CH_BACKSLASH);
    end else if (sel >= 93 && sel < 96 || sel >= 98) begin
      // Here sel 93..95 carries the high surrogate only; 98.. adds a partial \u.
      if (sel >= 98) begin
        push_byte(CH_BACKSLASH);
        push_byte(CH_U);
        push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
      end
    end else if (sel >= 89 && sel < 93) begin
      text_backlog.delete(text_backlog.size() - 1);
      text_backlog.delete(text_backlog.size() - 1);
      push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
    end
    push_end();
  endfunction

  function automatic void queue_random_string();
    bit aborted;
    int pieces;
    aborted = 1'b0;
    push_byte(CH_QUOTE);
    pieces = $urandom_range(1, 8);
    for (int i = 0; i < pieces && !aborted; i++) queue_segment(aborted);
    if (!aborted) queue_string_end();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Bytes and an end mark outside any string must produce nothing.
  task automatic test_idle_bytes();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_end();
    send_queued();
  endtask

  // Extremes of a plain byte, the eight simple escapes and a control byte.
  task automatic test_plain_and_simple_escapes();
    push_byte(CH_QUOTE);
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_str("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    push_byte(CH_QUOTE);
    push_byte(8'h1F);
    send_queued();
  endtask

  // \u escapes of each UTF-8 length, a lone low surrogate and two joined pairs.
  task automatic test_unicode_escapes();
    push_str("\"\\u0000\\u00e9\\uFFFF\\uDC00\\uD83D\\uDE00\\udbff\\udfff\"");
    send_queued();
  endtask

  // A high surrogate that is not followed by a low one: U+FFFD, then the
  // following bytes are decoded afresh.
  task automatic test_high_surrogate_recovery();
    push_str("\"\\uD800a\\uDBFF\\n\\uD800\\u0041\\uD800\\uDBFF\\uDFFF\\uDABC\"");
    push_str("\"\\uD800\\q");
    push_str("\"\\uD800\\u1x");
    send_queued();
  endtask

  // Unknown escape, bad hex and every place where the text can run out.
  task automatic test_error_endings();
    push_str("\"\\q\"\\u0g");
    push_str("\"a");
    push_end();
    push_str("\"\\");
    push_end();
    push_str("\"\\u1");
    push_end();
    push_str("\"\\uD800");
    push_end();
    push_str("\"\\uD800\\");
    push_end();
    push_str("\"\\uD800\\u1");
    push_end();
    send_queued();
  endtask

  task automatic test_random_strings(input int gap_pct, input int stall_pct,
                                     input int target);
    int start;
    text_beat_t t;
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    start = string_beats_sent;
    while (string_beats_sent - start < target) begin
      queue_random_string();
      send_queued();
      // Now and then some noise between strings, which the decoder ignores.
      if ($urandom_range(3) == 0) begin
        t.in_byte     = 8'($urandom_range(255));
        t.end_of_text = 1'($urandom_range(1));
        if (t.in_byte == CH_QUOTE) t.in_byte = 8'h00;
        send_beat(t);
      end
    end
  endtask

  // The receiver goes quiet for a long stretch while a long string is offered
  // without gaps, so the job queue fills and text_ready must drop.
  task automatic test_result_backpressure();
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    hold_request    = 200;
    push_byte(CH_QUOTE);
    for (int i = 0; i < 12; i++) push_byte(random_plain_byte());
    push_u(16'h20AC);
    push_byte(CH_QUOTE);
    send_queued();
    pause_until_drained();
  endtask

  // The sender stops while a high surrogate is waiting for its partner.
  task automatic test_pause_in_surrogate();
    push_str("\"x\\uD83D");
    send_queued();
    pause_until_drained();
    push_str("\\uDE00\"");
    send_queued();
  endtask

  initial begin
    rst        = 1'b1;
    text_valid = 1'b0;
    text       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct    = 20;
    ready_stall_pct = 20;
    test_idle_bytes();
    test_plain_and_simple_escapes();
    test_unicode_escapes();
    test_high_surrogate_recovery();
    test_error_endings();
    test_pause_in_surrogate();

    test_random_strings(30, 73, 10);
    test_random_strings(73, 30, 10);
    test_random_strings(0, 0, 10);
    test_result_backpressure();

    pause_until_drained();
    // Let any beat the block should not have produced come out and be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d result beats never arrived", expected_results.size()));
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
dv/testbench.sv
